/* rtl/bfr_pkg.sv */
// bfr_pkg: shared types, codes and the microcode table of the backlight fade engine.
// No dependencies; imported by the sequencer, datapath, top level and checker.
`default_nettype none

package bfr_pkg;

    localparam int PERIOD_BITS    = 10;
    localparam int CFG_DATA_BITS  = 10;
    localparam int CFG_INDEX_BITS = 1;
    localparam int STEP_BITS      = 4;

    localparam logic [PERIOD_BITS-1:0] DEFAULT_PERIOD_MS = 10'd20;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_UPDATE_PERIOD = 1'b0,
        REG_POWER_CTRL    = 1'b1
    } reg_index_t;

    localparam logic [1:0] PWR_NONE    = 2'd0;
    localparam logic [1:0] PWR_UNBLANK = 2'd1;
    localparam logic [1:0] PWR_DOWN    = 2'd2;

    typedef logic [STEP_BITS-1:0] step_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_CANCEL,
        OP_SET_NOW,
        OP_ADVANCE,
        OP_CLR_PHASE,
        OP_FINISH,
        OP_MUL,
        OP_DIV,
        OP_ROUND,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_TICK,
        C_TGT_EQ,
        C_DUR_LE,
        C_IDLE,
        C_PHASE_LT,
        C_EL_LT_DUR,
        C_DIV_BUSY,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic tick;
        logic tgt_eq;
        logic dur_le;
        logic running;
        logic phase_lt;
        logic el_lt_dur;
        logic div_busy;
    } status_t;

    typedef struct packed {
        op_t op;
    } ctrl_t;

    typedef struct packed {
        logic  take;
        logic  emit;
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    localparam step_t S_FETCH     = 4'd0;
    localparam step_t S_DECODE    = 4'd1;
    localparam step_t S_CHK_EQ    = 4'd2;
    localparam step_t S_CHK_DUR   = 4'd3;
    localparam step_t S_START     = 4'd4;
    localparam step_t S_CANCEL    = 4'd5;
    localparam step_t S_SET_NOW   = 4'd6;
    localparam step_t S_TICK      = 4'd7;
    localparam step_t S_ADVANCE   = 4'd8;
    localparam step_t S_CHK_PHASE = 4'd9;
    localparam step_t S_CHK_END   = 4'd10;
    localparam step_t S_FINISH    = 4'd11;
    localparam step_t S_MUL       = 4'd12;
    localparam step_t S_DIV       = 4'd13;
    localparam step_t S_ROUND     = 4'd14;
    localparam step_t S_EMIT      = 4'd15;

    // jump to target when cond holds, else fall through to step + 1
    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        begin
            unique case (s)
                S_FETCH:     w = '{1'b1, 1'b0, OP_LOAD,      C_NO_INPUT,  S_FETCH};
                S_DECODE:    w = '{1'b0, 1'b0, OP_NONE,      C_TICK,      S_TICK};
                S_CHK_EQ:    w = '{1'b0, 1'b0, OP_NONE,      C_TGT_EQ,    S_CANCEL};
                S_CHK_DUR:   w = '{1'b0, 1'b0, OP_NONE,      C_DUR_LE,    S_SET_NOW};
                S_START:     w = '{1'b0, 1'b0, OP_START,     C_ALWAYS,    S_EMIT};
                S_CANCEL:    w = '{1'b0, 1'b0, OP_CANCEL,    C_ALWAYS,    S_EMIT};
                S_SET_NOW:   w = '{1'b0, 1'b0, OP_SET_NOW,   C_ALWAYS,    S_EMIT};
                S_TICK:      w = '{1'b0, 1'b0, OP_NONE,      C_IDLE,      S_EMIT};
                S_ADVANCE:   w = '{1'b0, 1'b0, OP_ADVANCE,   C_NEVER,     S_FETCH};
                S_CHK_PHASE: w = '{1'b0, 1'b0, OP_NONE,      C_PHASE_LT,  S_EMIT};
                S_CHK_END:   w = '{1'b0, 1'b0, OP_CLR_PHASE, C_EL_LT_DUR, S_MUL};
                S_FINISH:    w = '{1'b0, 1'b0, OP_FINISH,    C_ALWAYS,    S_EMIT};
                S_MUL:       w = '{1'b0, 1'b0, OP_MUL,       C_NEVER,     S_FETCH};
                S_DIV:       w = '{1'b0, 1'b0, OP_DIV,       C_DIV_BUSY,  S_DIV};
                S_ROUND:     w = '{1'b0, 1'b0, OP_ROUND,     C_NEVER,     S_FETCH};
                S_EMIT:      w = '{1'b0, 1'b1, OP_EMIT,      C_OUT_BUSY,  S_EMIT};
                default:     w = '{1'b0, 1'b0, OP_NONE,      C_ALWAYS,    S_FETCH};
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/bfr_if.sv */
// bfr_if: valid/ready channel interfaces for request words and result words.
// No dependencies.
`default_nettype none

interface bfr_in_if #(
    parameter int LEVEL_BITS = 16,
    parameter int TIME_BITS  = 16
);
    logic                  valid;
    logic                  ready;
    logic                  action;
    logic [LEVEL_BITS-1:0] target_level;
    logic [TIME_BITS-1:0]  duration_ms;

    modport source (output valid, action, target_level, duration_ms, input ready);
    modport sink   (input valid, action, target_level, duration_ms, output ready);
endinterface

interface bfr_out_if #(
    parameter int LEVEL_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [LEVEL_BITS-1:0] level_out;
    logic                  level_written;
    logic [1:0]            power_command;
    logic                  fade_active;

    modport source (output valid, level_out, level_written, power_command, fade_active,
                    input ready);
    modport sink   (input valid, level_out, level_written, power_command, fade_active,
                    output ready);
endinterface

`default_nettype wire

/* rtl/bfr_sequencer.sv */
// bfr_sequencer: step counter, microcode fetch, conditional jumps and channel handshakes.
// Depends on bfr_pkg (microcode table, op and condition codes).
`default_nettype none

module bfr_sequencer (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire             out_ready,
    input  bfr_pkg::status_t status,
    output bfr_pkg::ctrl_t   ctrl
);
    import bfr_pkg::*;

    step_t  step_reg, step_next;
    logic   out_valid_reg, out_valid_next;
    ucode_t uw;
    logic   out_free;
    logic   fire;
    logic   jump;

    assign uw       = ucode_rom(step_reg);
    assign out_free = !out_valid_reg || out_ready;
    assign fire     = !(uw.take && !in_valid) && !(uw.emit && !out_free);

    assign in_ready  = uw.take;
    assign out_valid = out_valid_reg;
    assign ctrl.op   = fire ? uw.op : OP_NONE;

    always_comb
    begin
        unique case (uw.cond)
            C_NEVER:     jump = 1'b0;
            C_ALWAYS:    jump = 1'b1;
            C_NO_INPUT:  jump = !in_valid;
            C_TICK:      jump = status.tick;
            C_TGT_EQ:    jump = status.tgt_eq;
            C_DUR_LE:    jump = status.dur_le;
            C_IDLE:      jump = !status.running;
            C_PHASE_LT:  jump = status.phase_lt;
            C_EL_LT_DUR: jump = status.el_lt_dur;
            C_DIV_BUSY:  jump = status.div_busy;
            C_OUT_BUSY:  jump = !out_free;
            default:     jump = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next = jump ? uw.target : STEP_BITS'(step_reg + 1'b1);
        if (fire && uw.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_FETCH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/bfr_datapath.sv */
// bfr_datapath: fade state, config registers, multiplier, serial divider, output register.
// Depends on bfr_pkg (op codes, status and control structs, power codes).
`default_nettype none

module bfr_datapath #(
    parameter int LEVEL_BITS = 16,
    parameter int TIME_BITS  = 16
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  bfr_pkg::ctrl_t                       ctrl,
    output bfr_pkg::status_t                     status,
    input  wire                                  in_action,
    input  wire [LEVEL_BITS-1:0]                 in_target,
    input  wire [TIME_BITS-1:0]                  in_duration,
    input  wire                                  cfg_we,
    input  wire [bfr_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire [bfr_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    output logic [LEVEL_BITS-1:0]                out_level,
    output logic                                 out_written,
    output logic [1:0]                           out_cmd,
    output logic                                 out_active
);
    import bfr_pkg::*;

    localparam int PROD_BITS = LEVEL_BITS + TIME_BITS;
    localparam int CNT_BITS  = $clog2(PROD_BITS + 1);
    localparam int CMP_BITS  = (TIME_BITS > PERIOD_BITS) ? TIME_BITS : PERIOD_BITS;

    // config
    logic [PERIOD_BITS-1:0] period_reg;
    logic                   pwr_ctl_reg;

    // latched request
    logic                  act_reg;
    logic [LEVEL_BITS-1:0] tgt_reg;
    logic [TIME_BITS-1:0]  dur_in_reg;

    // fade state
    logic [LEVEL_BITS-1:0]  level_reg,   level_next;
    logic [LEVEL_BITS-1:0]  start_reg,   start_next;
    logic [LEVEL_BITS-1:0]  end_reg,     end_next;
    logic [TIME_BITS-1:0]   elapsed_reg, elapsed_next;
    logic [TIME_BITS-1:0]   rdur_reg,    rdur_next;
    logic [PERIOD_BITS-1:0] phase_reg,   phase_next;
    logic                   running_reg, running_next;
    logic                   written_reg, written_next;
    logic [1:0]             cmd_reg,     cmd_next;

    // divider
    logic [PROD_BITS-1:0] acc_reg, acc_next;
    logic [TIME_BITS:0]   rem_reg, rem_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;

    // output word
    logic [LEVEL_BITS-1:0] olevel_reg;
    logic                  owritten_reg;
    logic [1:0]            ocmd_reg;
    logic                  oactive_reg;

    logic                  down;
    logic [LEVEL_BITS-1:0] mag;
    logic [PROD_BITS-1:0]  prod;
    logic [TIME_BITS:0]    rem_sh;
    logic [TIME_BITS:0]    dur_w;
    logic                  sub_ok;
    logic                  round_up;
    logic [LEVEL_BITS-1:0] q_round;
    logic [LEVEL_BITS-1:0] ramp_pt;
    logic                  drv_en;
    logic [LEVEL_BITS-1:0] drv_lvl;
    logic [1:0]            drv_cmd;

    assign down     = end_reg < start_reg;
    assign mag      = down ? (start_reg - end_reg) : (end_reg - start_reg);
    assign prod     = PROD_BITS'(mag) * PROD_BITS'(elapsed_reg);
    assign dur_w    = {1'b0, rdur_reg};
    assign rem_sh   = {rem_reg[TIME_BITS-1:0], acc_reg[PROD_BITS-1]};
    assign sub_ok   = rem_sh >= dur_w;
    assign round_up = {rem_reg[TIME_BITS-1:0], 1'b0} >= dur_w;
    assign q_round  = acc_reg[LEVEL_BITS-1:0] + LEVEL_BITS'(round_up);
    assign ramp_pt  = down ? (start_reg - q_round) : (start_reg + q_round);

    assign status.tick      = act_reg;
    assign status.tgt_eq    = tgt_reg == level_reg;
    assign status.dur_le    = CMP_BITS'(dur_in_reg) <= CMP_BITS'(period_reg);
    assign status.running   = running_reg;
    assign status.phase_lt  = phase_reg < period_reg;
    assign status.el_lt_dur = elapsed_reg < rdur_reg;
    assign status.div_busy  = cnt_reg != CNT_BITS'(1);

    assign out_level   = olevel_reg;
    assign out_written = owritten_reg;
    assign out_cmd     = ocmd_reg;
    assign out_active  = oactive_reg;

    // level drive and the power command that goes with it
    always_comb
    begin
        drv_en  = 1'b0;
        drv_lvl = level_reg;
        case (ctrl.op)
            OP_SET_NOW:
            begin
                drv_en  = 1'b1;
                drv_lvl = tgt_reg;
            end
            OP_FINISH:
            begin
                drv_en  = end_reg != level_reg;
                drv_lvl = end_reg;
            end
            OP_ROUND:
            begin
                drv_en  = ramp_pt != level_reg;
                drv_lvl = ramp_pt;
            end
            default:
            begin
                drv_en  = 1'b0;
                drv_lvl = level_reg;
            end
        endcase
        drv_cmd = PWR_NONE;
        if (level_reg == '0 && pwr_ctl_reg)
        begin
            drv_cmd = PWR_UNBLANK;
        end
        if (drv_lvl == '0 && pwr_ctl_reg)
        begin
            drv_cmd = PWR_DOWN;
        end
    end

    always_comb
    begin
        level_next   = level_reg;
        start_next   = start_reg;
        end_next     = end_reg;
        elapsed_next = elapsed_reg;
        rdur_next    = rdur_reg;
        phase_next   = phase_reg;
        running_next = running_reg;
        written_next = written_reg;
        cmd_next     = cmd_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        unique case (ctrl.op) inside
            OP_LOAD:
            begin
                written_next = 1'b0;
                cmd_next     = PWR_NONE;
            end
            OP_START:
            begin
                elapsed_next = '0;
                rdur_next    = dur_in_reg;
                start_next   = level_reg;
                end_next     = tgt_reg;
                if (!running_reg)
                begin
                    running_next = 1'b1;
                    phase_next   = '0;
                end
            end
            OP_CANCEL, OP_SET_NOW:
            begin
                running_next = 1'b0;
                elapsed_next = '0;
                rdur_next    = '0;
                phase_next   = '0;
                start_next   = level_reg;
                end_next     = level_reg;
            end
            OP_ADVANCE:
            begin
                if (elapsed_reg != '1)
                begin
                    elapsed_next = elapsed_reg + 1'b1;
                end
                phase_next = phase_reg + 1'b1;
            end
            OP_CLR_PHASE:
            begin
                phase_next = '0;
            end
            OP_FINISH:
            begin
                running_next = 1'b0;
            end
            OP_MUL:
            begin
                acc_next = prod;
                rem_next = '0;
                cnt_next = CNT_BITS'(PROD_BITS);
            end
            OP_DIV:
            begin
                rem_next = sub_ok ? (rem_sh - dur_w) : rem_sh;
                acc_next = {acc_reg[PROD_BITS-2:0], sub_ok};
                cnt_next = cnt_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
        if (drv_en)
        begin
            level_next   = drv_lvl;
            written_next = 1'b1;
            cmd_next     = drv_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= DEFAULT_PERIOD_MS;
            pwr_ctl_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_UPDATE_PERIOD: period_reg  <= cfg_data[PERIOD_BITS-1:0];
                REG_POWER_CTRL:    pwr_ctl_reg <= cfg_data[0];
                default:           period_reg  <= period_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= '0;
            start_reg   <= '0;
            end_reg     <= '0;
            elapsed_reg <= '0;
            rdur_reg    <= '0;
            phase_reg   <= '0;
            running_reg <= 1'b0;
            written_reg <= 1'b0;
            cmd_reg     <= PWR_NONE;
            cnt_reg     <= '0;
        end
        else
        begin
            level_reg   <= level_next;
            start_reg   <= start_next;
            end_reg     <= end_next;
            elapsed_reg <= elapsed_next;
            rdur_reg    <= rdur_next;
            phase_reg   <= phase_next;
            running_reg <= running_next;
            written_reg <= written_next;
            cmd_reg     <= cmd_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        if (ctrl.op == OP_LOAD)
        begin
            act_reg    <= in_action;
            tgt_reg    <= in_target;
            dur_in_reg <= in_duration;
        end
        if (ctrl.op == OP_EMIT)
        begin
            olevel_reg   <= level_reg;
            owritten_reg <= written_reg;
            ocmd_reg     <= cmd_reg;
            oactive_reg  <= running_reg;
        end
    end

endmodule

`default_nettype wire

/* rtl/backlight_fade_ramp.sv */
// Backlight fade engine, top level. One word in, one result word out.
// A set request ends in a cancel, a direct set or a ramp start. A tick returns at once when idle
// or off a period boundary, finishes the fade at the ramp end, and else updates the ramp point,
// computed by the one-bit-a-cycle restoring divider. Next word is taken the cycle after the result
// is registered; the emit step stalls while the previous result still waits for ready.
// Reset clears level, ramp state and output valid; period 20 ms, power control on.
// Depends on bfr_pkg, bfr_if, bfr_sequencer, bfr_datapath.
`default_nettype none

module backlight_fade_ramp #(
    parameter int LEVEL_BITS = 16,
    parameter int TIME_BITS  = 16
) (
    input  wire                                clk,
    input  wire                                rst_n,
    bfr_in_if.sink                             in_ch,
    bfr_out_if.source                          out_ch,
    input  wire                                cfg_we,
    input  wire [bfr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire [bfr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import bfr_pkg::*;

    status_t status;
    ctrl_t   ctrl;

    bfr_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .ctrl      (ctrl)
    );

    bfr_datapath #(
        .LEVEL_BITS (LEVEL_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .status      (status),
        .in_action   (in_ch.action),
        .in_target   (in_ch.target_level),
        .in_duration (in_ch.duration_ms),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_level   (out_ch.level_out),
        .out_written (out_ch.level_written),
        .out_cmd     (out_ch.power_command),
        .out_active  (out_ch.fade_active)
    );

endmodule

`default_nettype wire

/* rtl/bfr_checker.sv */
// bfr_checker: port-level assertions for the backlight fade engine, bound to the top level.
// Depends on bfr_pkg (power codes) and backlight_fade_ramp.
`default_nettype none

module bfr_checker #(
    parameter int LEVEL_BITS = 16
) (
    input wire                  clk,
    input wire                  rst_n,
    input wire                  in_valid,
    input wire                  in_ready,
    input wire                  out_valid,
    input wire                  out_ready,
    input wire [LEVEL_BITS-1:0] level_out,
    input wire                  level_written,
    input wire [1:0]            power_command
);
    import bfr_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(level_out) && $stable(power_command)
                                    && $stable(level_written))
        else $error("result word changed while stalled");

    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word taken while one is in work");

    a_down_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && power_command == PWR_DOWN |-> level_written && level_out == '0)
        else $error("powerdown without a write to zero");

    a_unblank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && power_command == PWR_UNBLANK |-> level_written && level_out != '0)
        else $error("unblank without a write above zero");

endmodule

bind backlight_fade_ramp bfr_checker #(
    .LEVEL_BITS (LEVEL_BITS)
) u_bfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .level_out     (out_ch.level_out),
    .level_written (out_ch.level_written),
    .power_command (out_ch.power_command)
);

`default_nettype wire
